@@ sv/bmd_pkg.sv @@
// Shared types, constants and codes of the block motion detector.
`default_nettype none

package bmd_pkg;

    localparam int MAX_TILES_DEF = 32;

    localparam int PIX_W      = 8;
    localparam int TILE_DIM_W = 9;
    localparam int FRAME_DIM_W = 13;
    localparam int POS_W      = 12;
    localparam int SUB_W      = 8;
    localparam int SUM_W      = 24;
    localparam int BASE_W     = 25;
    localparam int IDX_OUT_W  = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int DIV_STEPS  = FRAME_DIM_W;

    localparam logic [TILE_DIM_W-1:0]  TILE_DIM_MAX  = 9'd256;
    localparam logic [FRAME_DIM_W-1:0] FRAME_DIM_MAX = 13'd4096;
    localparam logic [SUM_W-1:0]       SUM_SAT       = 24'hFFFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_W  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_H  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H = 2'd3;

    localparam logic [1:0] DIV_SEL_TX  = 2'd0;
    localparam logic [1:0] DIV_SEL_TY  = 2'd1;
    localparam logic [1:0] DIV_SEL_COL = 2'd2;
    localparam logic [1:0] DIV_SEL_ROW = 2'd3;

    localparam logic OUT_KIND_PIXEL = 1'b0;
    localparam logic OUT_KIND_FLAG  = 1'b1;

    typedef struct packed {
        logic [TILE_DIM_W-1:0]  tw;
        logic [TILE_DIM_W-1:0]  th;
        logic [FRAME_DIM_W-1:0] fw;
        logic [FRAME_DIM_W-1:0] fh;
        logic [FRAME_DIM_W-1:0] tx;
        logic [FRAME_DIM_W-1:0] ty;
        logic [SUM_W-1:0]       thr_init;
    } t_geom;

    typedef struct packed {
        logic [SUB_W-1:0]  cx;
        logic [POS_W-1:0]  tcx;
        logic [SUB_W-1:0]  ry;
        logic [POS_W-1:0]  tcy;
        logic [BASE_W-1:0] rowbase;
    } t_pos;

    typedef enum logic [2:0] {
        G_START,
        G_WAIT,
        G_MUL_A,
        G_MUL_B,
        G_MUL_C,
        G_LOAD,
        G_READY
    } t_geo_state;

    typedef enum logic [2:0] {
        T_CLEAR,
        T_RUN,
        T_SCAN,
        T_FLAG_RD,
        T_FLAG_OUT
    } t_bmd_state;

endpackage

`default_nettype wire

@@ sv/bmd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bmd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/bmd_div.sv @@
// Restoring divider, one quotient bit per cycle, for the tile geometry.
`default_nettype none

module bmd_div
    import bmd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [FRAME_DIM_W-1:0] i_dividend,
    input  wire logic [TILE_DIM_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [FRAME_DIM_W-1:0]      o_quotient,
    output logic [TILE_DIM_W-1:0]       o_remainder
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [FRAME_DIM_W-1:0] r_quo;
    logic [TILE_DIM_W-1:0]  r_rem;
    logic [TILE_DIM_W-1:0]  r_dvs;

    logic [TILE_DIM_W:0]    shifted;
    logic [TILE_DIM_W+1:0]  trial;
    logic                   q_bit;
    logic [TILE_DIM_W-1:0]  n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[FRAME_DIM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_dvs};
        q_bit   = ~trial[TILE_DIM_W+1];
        n_rem   = q_bit ? trial[TILE_DIM_W-1:0] : shifted[TILE_DIM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[FRAME_DIM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

@@ sv/bmd_geom.sv @@
// Configuration registers and the sequencer that derives the tile geometry.
`default_nettype none

module bmd_geom
    import bmd_pkg::*;
#(
    parameter int MAX_TILES = MAX_TILES_DEF,
    localparam int CNT_W = $clog2(MAX_TILES + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready,
    input  wire logic [POS_W-1:0]      i_column,
    input  wire logic [POS_W-1:0]      i_row,
    output t_geom                      o_geom,
    output logic [CNT_W-1:0]           o_ntiles,
    output t_pos                       o_pos,
    output logic                       o_load,
    output logic                       o_ready
);

    t_geo_state n_state;
    t_geo_state r_state;

    logic [1:0]             r_sel;
    logic [TILE_DIM_W-1:0]  r_tw;
    logic [TILE_DIM_W-1:0]  r_th;
    logic [FRAME_DIM_W-1:0] r_fw;
    logic [FRAME_DIM_W-1:0] r_fh;
    logic [FRAME_DIM_W-1:0] r_tx;
    logic [FRAME_DIM_W-1:0] r_ty;
    logic [POS_W-1:0]       r_tcx;
    logic [SUB_W-1:0]       r_cx;
    logic [POS_W-1:0]       r_tcy;
    logic [SUB_W-1:0]       r_ry;
    logic [2*FRAME_DIM_W-1:0] r_txty;
    logic [2*TILE_DIM_W-1:0]  r_twth;
    logic [SUM_W-1:0]       r_thr;
    logic [BASE_W-1:0]      r_rowbase;
    logic [CNT_W-1:0]       r_ntiles;

    logic                   cfg_wr;
    logic                   div_start;
    logic                   div_done;
    logic [FRAME_DIM_W-1:0] div_dividend;
    logic [TILE_DIM_W-1:0]  div_divisor;
    logic [FRAME_DIM_W-1:0] div_quo;
    logic [TILE_DIM_W-1:0]  div_rem;
    logic [TILE_DIM_W-1:0]  tile_clamped;
    logic [FRAME_DIM_W-1:0] frame_clamped;
    logic [2*TILE_DIM_W+7:0] thr_wide;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_comb begin
        if (i_cfg_data[TILE_DIM_W-1:0] == '0) begin
            tile_clamped = TILE_DIM_W'(1);
        end else if (i_cfg_data[TILE_DIM_W-1:0] > TILE_DIM_MAX) begin
            tile_clamped = TILE_DIM_MAX;
        end else begin
            tile_clamped = i_cfg_data[TILE_DIM_W-1:0];
        end
        if (i_cfg_data == '0) begin
            frame_clamped = FRAME_DIM_W'(1);
        end else if (i_cfg_data > FRAME_DIM_MAX) begin
            frame_clamped = FRAME_DIM_MAX;
        end else begin
            frame_clamped = i_cfg_data;
        end
    end

    always_comb begin
        case (r_sel)
            DIV_SEL_TX: begin
                div_dividend = r_fw;
                div_divisor  = r_tw;
            end
            DIV_SEL_TY: begin
                div_dividend = r_fh;
                div_divisor  = r_th;
            end
            DIV_SEL_COL: begin
                div_dividend = {1'b0, i_column};
                div_divisor  = r_tw;
            end
            DIV_SEL_ROW: begin
                div_dividend = {1'b0, i_row};
                div_divisor  = r_th;
            end
            default: begin
                div_dividend = r_fw;
                div_divisor  = r_tw;
            end
        endcase
    end

    bmd_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state = r_state;
        if (cfg_wr) begin
            n_state = G_START;
        end else begin
            case (r_state)
                G_START: n_state = G_WAIT;
                G_WAIT: begin
                    if (div_done) begin
                        n_state = (r_sel == DIV_SEL_ROW) ? G_MUL_A : G_START;
                    end
                end
                G_MUL_A: n_state = G_MUL_B;
                G_MUL_B: n_state = G_MUL_C;
                G_MUL_C: n_state = G_LOAD;
                G_LOAD:  n_state = G_READY;
                G_READY: n_state = G_READY;
                default: n_state = G_START;
            endcase
        end
    end

    always_comb begin
        div_start = 1'b0;
        o_load    = 1'b0;
        o_ready   = 1'b0;
        case (r_state)
            G_START: div_start = 1'b1;
            G_LOAD:  o_load    = 1'b1;
            G_READY: o_ready   = 1'b1;
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign thr_wide = {r_twth, 8'h00} - {8'h00, r_twth};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_START;
            r_sel   <= DIV_SEL_TX;
            r_tw    <= TILE_DIM_W'(16);
            r_th    <= TILE_DIM_W'(16);
            r_fw    <= FRAME_DIM_W'(128);
            r_fh    <= FRAME_DIM_W'(64);
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_sel <= DIV_SEL_TX;
                case (i_cfg_index)
                    REG_TILE_W:  r_tw <= tile_clamped;
                    REG_TILE_H:  r_th <= tile_clamped;
                    REG_FRAME_W: r_fw <= frame_clamped;
                    REG_FRAME_H: r_fh <= frame_clamped;
                    default: begin
                        r_tw <= r_tw;
                    end
                endcase
            end else if (r_state == G_WAIT && div_done) begin
                r_sel <= r_sel + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == G_WAIT && div_done) begin
            case (r_sel)
                DIV_SEL_TX: r_tx <= div_quo;
                DIV_SEL_TY: r_ty <= div_quo;
                DIV_SEL_COL: begin
                    r_tcx <= div_quo[POS_W-1:0];
                    r_cx  <= div_rem[SUB_W-1:0];
                end
                DIV_SEL_ROW: begin
                    r_tcy <= div_quo[POS_W-1:0];
                    r_ry  <= div_rem[SUB_W-1:0];
                end
                default: begin
                    r_tx <= div_quo;
                end
            endcase
        end
        if (r_state == G_MUL_A) begin
            r_txty <= r_tx * r_ty;
        end
        if (r_state == G_MUL_B) begin
            r_twth <= r_tw * r_th;
            if (r_txty > (2*FRAME_DIM_W)'(MAX_TILES)) begin
                r_ntiles <= CNT_W'(MAX_TILES);
            end else begin
                r_ntiles <= r_txty[CNT_W-1:0];
            end
        end
        if (r_state == G_MUL_C) begin
            r_thr     <= thr_wide[SUM_W-1:0];
            r_rowbase <= r_tcy * r_tx;
        end
    end

    always_comb begin
        o_geom.tw       = r_tw;
        o_geom.th       = r_th;
        o_geom.fw       = r_fw;
        o_geom.fh       = r_fh;
        o_geom.tx       = r_tx;
        o_geom.ty       = r_ty;
        o_geom.thr_init = r_thr;
        o_pos.cx        = r_cx;
        o_pos.tcx       = r_tcx;
        o_pos.ry        = r_ry;
        o_pos.tcy       = r_tcy;
        o_pos.rowbase   = r_rowbase;
    end

    assign o_ntiles = r_ntiles;

endmodule

`default_nettype wire

@@ sv/block_motion_detector.sv @@
// Block motion detector: pixel differences, per-tile sums and end-of-frame motion flags.
// Pixel pairs enter on the slave stream in raster order, one per request. Each pixel
// request gives one difference result on the master stream, kind 0 on tuser. The
// request that ends a frame is followed by one motion flag result per tile, kind 1,
// and tlast marks the final result that a request causes. Tile sums live in a
// MAX_TILES-entry RAM that is read, updated and written back per pixel, overlapped,
// with the previous write forwarded, so one pixel is accepted per cycle while the
// output is free and a difference result appears in the cycle after its request.
// At the end of a frame the block reads the sums once to find the minimum, then reads
// them again to emit the flags, then clears the sums that were not already cleared.
// No pixel is accepted during this pass.
// The configuration channel is always ready. After reset and after every register
// write a shared 13-step divider recomputes the tile geometry and the current tile
// position; no pixel is accepted while it runs. After reset the tile RAM is also
// cleared in a pass that runs alongside.
// A stalled receiver holds the current result in the output register; the block
// keeps accepting pixels as long as that register is emptied in the same cycle.
`default_nettype none

module block_motion_detector
    import bmd_pkg::*;
#(
    parameter int MAX_TILES = MAX_TILES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [7:0] current_pixel, [15:8] base_pixel
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [7:0] diff_pixel, [12:8] tile_index, [13] motion, [37:14] tile_sum,
    // [61:38] threshold, [63:62] zero
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // [0] kind
    output logic                       o_m_axis_tuser,
    output logic                       o_m_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int CNT_W = $clog2(MAX_TILES + 1);

    t_bmd_state n_state;
    t_bmd_state r_state;

    t_geom            geom;
    t_pos             geo_pos;
    logic [CNT_W-1:0] ntiles;
    logic             geo_load;
    logic             geo_ready;

    logic [POS_W-1:0]  r_column;
    logic [POS_W-1:0]  r_row;
    logic [SUB_W-1:0]  r_cx;
    logic [POS_W-1:0]  r_tcx;
    logic [SUB_W-1:0]  r_ry;
    logic [POS_W-1:0]  r_tcy;
    logic [BASE_W-1:0] r_rowbase;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_scan_v;
    logic [SUM_W-1:0]  r_min;

    logic              r_s1_valid;
    logic [IDX_W-1:0]  r_s1_addr;
    logic [PIX_W-1:0]  r_s1_diff;

    logic              r_fw_valid;
    logic [IDX_W-1:0]  r_fw_addr;
    logic [SUM_W-1:0]  r_fw_data;
    logic [IDX_W-1:0]  r_rd_addr;

    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [PIX_W-1:0]     r_out_diff;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic                 r_out_mot;
    logic [SUM_W-1:0]     r_out_sum;
    logic [SUM_W-1:0]     r_out_thr;
    logic                 r_out_last;

    logic [PIX_W-1:0]     cur_pix;
    logic [PIX_W-1:0]     base_pix;
    logic [PIX_W-1:0]     diff;
    logic [FRAME_DIM_W-1:0] col_p1;
    logic [FRAME_DIM_W-1:0] row_p1;
    logic                 col_last;
    logic                 row_last;
    logic                 cx_last;
    logic                 ry_last;
    logic                 frame_end;
    logic [BASE_W-1:0]    tile_num;
    logic                 hit;
    logic                 out_free;
    logic                 in_ready;
    logic                 accept;
    logic                 scan_issue;
    logic                 flag_last;
    logic                 clear_we;
    logic [SUM_W-1:0]     ram_rdata;
    logic [SUM_W-1:0]     rdf;
    logic [SUM_W:0]       sum_wide;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SUM_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic                 load_pix;
    logic                 load_flag;
    logic [31:0]          cnt_ext;

    bmd_geom #(
        .MAX_TILES (MAX_TILES)
    ) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_column    (r_column),
        .i_row       (r_row),
        .o_geom      (geom),
        .o_ntiles    (ntiles),
        .o_pos       (geo_pos),
        .o_load      (geo_load),
        .o_ready     (geo_ready)
    );

    bmd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_TILES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        cur_pix   = i_s_axis_tdata[PIX_W-1:0];
        base_pix  = i_s_axis_tdata[2*PIX_W-1:PIX_W];
        diff      = (cur_pix > base_pix) ? (cur_pix - base_pix) : '0;
        col_p1    = {1'b0, r_column} + FRAME_DIM_W'(1);
        row_p1    = {1'b0, r_row} + FRAME_DIM_W'(1);
        col_last  = col_p1 >= geom.fw;
        row_last  = row_p1 >= geom.fh;
        cx_last   = ({1'b0, r_cx} + TILE_DIM_W'(1)) == geom.tw;
        ry_last   = ({1'b0, r_ry} + TILE_DIM_W'(1)) == geom.th;
        frame_end = col_last && row_last;
        tile_num  = r_rowbase + BASE_W'(r_tcx);
        hit       = ({1'b0, r_tcx} < geom.tx) && ({1'b0, r_tcy} < geom.ty)
                    && (tile_num < BASE_W'(ntiles));
        rdf       = (r_fw_valid && (r_fw_addr == r_rd_addr)) ? r_fw_data : ram_rdata;
        sum_wide  = {1'b0, rdf} + (SUM_W+1)'(r_s1_diff);
        out_free  = !r_out_valid || i_m_axis_tready;
        scan_issue = r_cnt < ntiles;
        flag_last = (r_cnt + CNT_W'(1)) == ntiles;
        cnt_ext   = 32'(r_cnt);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_CLEAR: begin
                if (r_cnt == CNT_W'(MAX_TILES)) begin
                    n_state = T_RUN;
                end
            end
            T_RUN: begin
                if (accept && frame_end) begin
                    n_state = (ntiles != '0) ? T_SCAN : T_CLEAR;
                end
            end
            T_SCAN: begin
                if (!scan_issue && r_scan_v) begin
                    n_state = T_FLAG_RD;
                end
            end
            T_FLAG_RD: n_state = T_FLAG_OUT;
            T_FLAG_OUT: begin
                if (out_free) begin
                    n_state = flag_last ? T_CLEAR : T_FLAG_RD;
                end
            end
            default: n_state = T_CLEAR;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        load_flag = 1'b0;
        clear_we  = 1'b0;
        ram_raddr = r_cnt[IDX_W-1:0];
        case (r_state)
            T_RUN: begin
                in_ready  = geo_ready && out_free;
                ram_raddr = tile_num[IDX_W-1:0];
            end
            T_FLAG_OUT: load_flag = out_free;
            T_CLEAR:    clear_we  = (r_cnt != CNT_W'(MAX_TILES)) && !r_s1_valid;
            default: begin
                in_ready = 1'b0;
            end
        endcase
        accept   = i_s_axis_tvalid && in_ready;
        load_pix = accept;

        ram_we    = 1'b0;
        ram_waddr = r_cnt[IDX_W-1:0];
        ram_wdata = '0;
        if (r_s1_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_s1_addr;
            ram_wdata = sum_wide[SUM_W] ? SUM_SAT : sum_wide[SUM_W-1:0];
        end else if (load_flag || clear_we) begin
            ram_we = 1'b1;
        end
    end

    assign o_s_axis_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_CLEAR;
            r_cnt      <= '0;
            r_scan_v   <= 1'b0;
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
            r_column   <= '0;
            r_row      <= '0;
            r_cx       <= '0;
            r_tcx      <= '0;
            r_ry       <= '0;
            r_tcy      <= '0;
            r_rowbase  <= '0;
        end else begin
            r_state    <= n_state;
            r_fw_valid <= ram_we;
            r_s1_valid <= accept && hit;

            if (geo_load) begin
                r_cx      <= geo_pos.cx;
                r_tcx     <= geo_pos.tcx;
                r_ry      <= geo_pos.ry;
                r_tcy     <= geo_pos.tcy;
                r_rowbase <= geo_pos.rowbase;
            end else if (accept) begin
                if (col_last) begin
                    r_column <= '0;
                    r_cx     <= '0;
                    r_tcx    <= '0;
                    if (row_last) begin
                        r_row     <= '0;
                        r_ry      <= '0;
                        r_tcy     <= '0;
                        r_rowbase <= '0;
                    end else begin
                        r_row <= row_p1[POS_W-1:0];
                        if (ry_last) begin
                            r_ry      <= '0;
                            r_tcy     <= r_tcy + POS_W'(1);
                            r_rowbase <= r_rowbase + BASE_W'(geom.tx);
                        end else begin
                            r_ry <= r_ry + SUB_W'(1);
                        end
                    end
                end else begin
                    r_column <= col_p1[POS_W-1:0];
                    if (cx_last) begin
                        r_cx  <= '0;
                        r_tcx <= r_tcx + POS_W'(1);
                    end else begin
                        r_cx <= r_cx + SUB_W'(1);
                    end
                end
            end

            case (r_state)
                T_RUN: begin
                    if (accept && frame_end) begin
                        r_cnt    <= '0;
                        r_scan_v <= 1'b0;
                    end
                end
                T_SCAN: begin
                    if (scan_issue) begin
                        r_cnt    <= r_cnt + CNT_W'(1);
                        r_scan_v <= 1'b1;
                    end else begin
                        r_scan_v <= 1'b0;
                        if (r_scan_v) begin
                            r_cnt <= '0;
                        end
                    end
                end
                T_FLAG_OUT: begin
                    if (out_free) begin
                        r_cnt <= flag_last ? ntiles : (r_cnt + CNT_W'(1));
                    end
                end
                T_CLEAR: begin
                    if (clear_we) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                default: begin
                    r_scan_v <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= ram_waddr;
        r_fw_data <= ram_wdata;
        r_rd_addr <= ram_raddr;
        if (accept) begin
            r_s1_addr <= tile_num[IDX_W-1:0];
            r_s1_diff <= diff;
        end
        if (r_state == T_RUN && accept && frame_end) begin
            r_min <= geom.thr_init;
        end else if (r_state == T_SCAN && r_scan_v && (rdf < r_min)) begin
            r_min <= rdf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_pix) begin
            r_out_valid <= 1'b1;
            r_out_kind  <= OUT_KIND_PIXEL;
            r_out_diff  <= diff;
            r_out_idx   <= '0;
            r_out_mot   <= 1'b0;
            r_out_sum   <= '0;
            r_out_thr   <= '0;
            r_out_last  <= !(frame_end && (ntiles != '0));
        end else if (load_flag) begin
            r_out_valid <= 1'b1;
            r_out_kind  <= OUT_KIND_FLAG;
            r_out_diff  <= '0;
            r_out_idx   <= cnt_ext[IDX_OUT_W-1:0];
            r_out_mot   <= rdf > r_min;
            r_out_sum   <= rdf;
            r_out_thr   <= r_min;
            r_out_last  <= flag_last;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_thr, r_out_sum, r_out_mot, r_out_idx, r_out_diff};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    a_s1_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(accept))
        else $error("tile update without a preceding pixel request");

    a_s1_read_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_rd_addr == r_s1_addr))
        else $error("tile update uses data read from another entry");

    a_flag_not_below_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == OUT_KIND_FLAG)) |-> (r_out_mot || (r_out_sum == r_out_thr)))
        else $error("tile sum below the frame threshold");

endmodule

`default_nettype wire
